// ----- rtl/mexp_pkg.sv -----
// Shared constants, state encoding and controller/datapath command types for modular exponentiation.
package mexp_pkg;

	localparam int MEXP_OPERAND_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQ_START,
		ST_SQR,
		ST_FINISH
	} ctl_state_t;

	typedef enum logic {
		SEL_ANS,
		SEL_SQ
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     init;
		logic     reduce_step;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     mul_step;
		logic     mul_write;
		logic     exp_shift;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic special;
		logic exp_bit;
	} dp_status_t;

endpackage

// ----- rtl/mexp_req_if.sv -----
// Request channel carrying base, exponent and modulus.
interface mexp_req_if #(
	parameter int WIDTH = mexp_pkg::MEXP_OPERAND_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base_value;
	logic [WIDTH-1:0] exponent_value;
	logic [WIDTH-1:0] modulus_value;

	modport source (output valid, input ready, output base_value, output exponent_value,
		output modulus_value);
	modport sink (input valid, output ready, input base_value, input exponent_value,
		input modulus_value);
endinterface

// ----- rtl/mexp_rsp_if.sv -----
// Response channel carrying the reduced power.
interface mexp_rsp_if #(
	parameter int WIDTH = mexp_pkg::MEXP_OPERAND_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] power_result;

	modport source (output valid, input ready, output power_result);
	modport sink (input valid, output ready, input power_result);
endinterface

// ----- rtl/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: channel wiring of controller and datapath.
//
// Usage: a request on req carries base_value, exponent_value and modulus_value
// (OPERAND_WIDTH bits each, unsigned). The block returns one response on rsp
// holding power_result, base raised to the exponent and reduced by the modulus.
// A zero exponent returns one without reduction; a zero modulus with a nonzero
// exponent returns zero. Both go from acceptance through the init and finish states
// to the output register. Otherwise the base is first reduced, one remainder bit
// a cycle. Then each exponent bit, least significant first, takes a squaring
// and, if the bit is set, a multiplication of the square into the answer.
// Every multiplication runs one add-and-reduce step a cycle through the single
// shared multiplier unit, which sets the rate.
// One request is worked on at a time. The result is held in an output register, so a
// new request is accepted as soon as the result is loaded, even while the receiver
// stalls; if the previous result still waits, the finished one holds until it is
// taken. Reset clears the controller to idle with no response pending.
module modular_exponentiation #(
	parameter int OPERAND_WIDTH = mexp_pkg::MEXP_OPERAND_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	mexp_req_if.sink  req,
	mexp_rsp_if.source rsp
);
	import mexp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller sequences the whole computation and owns the response valid flag.
	mexp_controller #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the operands, the running square and answer, and the result.
	mexp_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.base_value     (req.base_value),
		.exponent_value (req.exponent_value),
		.modulus_value  (req.modulus_value),
		.power_result   (rsp.power_result)
	);

endmodule

// ----- rtl/mexp_datapath.sv -----
// Operand registers, add-and-reduce multiplier, base reduction and result register.
module mexp_datapath #(
	parameter int OPERAND_WIDTH = mexp_pkg::MEXP_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mexp_pkg::dp_cmd_t        cmd,
	output mexp_pkg::dp_status_t     status,
	input  logic [OPERAND_WIDTH-1:0] base_value,
	input  logic [OPERAND_WIDTH-1:0] exponent_value,
	input  logic [OPERAND_WIDTH-1:0] modulus_value,
	output logic [OPERAND_WIDTH-1:0] power_result
);
	import mexp_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic [W-1:0] m_q, e_q, b_q, sq_q, ans_q, acc_q, x_q, y_q, result_q;
	logic [W:0]   m_ext;
	logic [W:0]   rem_ext, rem_sub;
	logic [W-1:0] rem_next;
	logic [W:0]   acc_sum, dbl_sum;
	logic [W-1:0] acc_red, dbl_red, acc_next;
	logic [W-1:0] ans_init;

	assign m_ext = {1'b0, m_q};

	// One restoring step of base mod m: the partial remainder stays below m.
	assign rem_ext  = {sq_q, b_q[W-1]};
	assign rem_sub  = rem_ext - m_ext;
	assign rem_next = (rem_ext >= m_ext) ? rem_sub[W-1:0] : rem_ext[W-1:0];

	// Two independent add-and-reduce operations per multiplier step.
	assign acc_sum  = {1'b0, acc_q} + {1'b0, x_q};
	assign dbl_sum  = {1'b0, x_q} + {1'b0, x_q};
	assign acc_red  = (acc_sum >= m_ext) ? W'(acc_sum - m_ext) : acc_sum[W-1:0];
	assign dbl_red  = (dbl_sum >= m_ext) ? W'(dbl_sum - m_ext) : dbl_sum[W-1:0];
	assign acc_next = y_q[0] ? acc_red : acc_q;

	// A zero exponent yields one unreduced; otherwise one mod m, or zero for m of zero.
	assign ans_init = (e_q == '0) ? W'(1) :
		((m_q == '0) || (m_q == W'(1))) ? '0 : W'(1);

	assign status.special = (e_q == '0) || (m_q == '0);
	assign status.exp_bit = e_q[0];
	assign power_result   = result_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q <= modulus_value;
			e_q <= exponent_value;
			b_q <= base_value;
		end else begin
			if (cmd.reduce_step) begin
				b_q <= b_q << 1;
			end
			if (cmd.exp_shift) begin
				e_q <= e_q >> 1;
			end
		end

		if (cmd.init) begin
			ans_q <= ans_init;
			sq_q  <= '0;
		end else if (cmd.reduce_step) begin
			sq_q <= rem_next;
		end else if (cmd.mul_write) begin
			if (cmd.mul_sel == SEL_ANS) begin
				ans_q <= acc_next;
			end else begin
				sq_q <= acc_next;
			end
		end

		if (cmd.mul_start) begin
			acc_q <= '0;
			x_q   <= (cmd.mul_sel == SEL_ANS) ? ans_q : sq_q;
			y_q   <= sq_q;
		end else if (cmd.mul_step) begin
			acc_q <= acc_next;
			x_q   <= dbl_red;
			y_q   <= y_q >> 1;
		end

		if (cmd.out_load) begin
			result_q <= ans_q;
		end
	end

	a_reduce_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reduce_step |=> (sq_q < m_q))
		else $error("base remainder not below modulus");
	a_ans_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_write && cmd.mul_sel == SEL_ANS) |=> (ans_q < m_q))
		else $error("running answer not below modulus");
	a_double_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_step |=> (x_q < m_q))
		else $error("doubled operand not below modulus");

endmodule

// ----- rtl/mexp_controller.sv -----
// Sequencer for base reduction, exponent bit scan and multiplier steps.
module mexp_controller #(
	parameter int OPERAND_WIDTH = mexp_pkg::MEXP_OPERAND_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  mexp_pkg::dp_status_t status,
	output mexp_pkg::dp_cmd_t    cmd
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(OPERAND_WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(OPERAND_WIDTH - 1);

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] step_cnt_q, bit_cnt_q;
	logic             out_valid_q;
	logic             req_fire, out_free, step_last, bit_last;

	assign req_fire  = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign step_last = (step_cnt_q == LAST);
	assign bit_last  = (bit_cnt_q == LAST);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (req_valid) state_d = ST_INIT;
			ST_INIT:     state_d = status.special ? ST_FINISH : ST_REDUCE;
			ST_REDUCE:   if (step_last) state_d = ST_BIT;
			ST_BIT:      state_d = status.exp_bit ? ST_MUL : ST_SQR;
			ST_MUL:      if (step_last) state_d = ST_SQ_START;
			ST_SQ_START: state_d = ST_SQR;
			ST_SQR: begin
				if (step_last) state_d = bit_last ? ST_FINISH : ST_BIT;
			end
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		cmd.mul_sel = SEL_SQ;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_INIT: cmd.init = 1'b1;
			ST_REDUCE: cmd.reduce_step = 1'b1;
			ST_BIT: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = status.exp_bit ? SEL_ANS : SEL_SQ;
			end
			ST_MUL: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_sel   = SEL_ANS;
				cmd.mul_write = step_last;
			end
			ST_SQ_START: cmd.mul_start = 1'b1;
			ST_SQR: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_write = step_last;
				cmd.exp_shift = step_last;
			end
			ST_FINISH: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_cnt_q  <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR) begin
				step_cnt_q <= step_last ? '0 : step_cnt_q + 1'b1;
			end else begin
				step_cnt_q <= '0;
			end
			if (state_q == ST_INIT) begin
				bit_cnt_q <= '0;
			end else if (state_q == ST_SQR && step_last) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_INIT))
		else $error("accepted request did not start a computation");
	a_finish_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not presented");
	a_all_bits_scanned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR && state_d == ST_FINISH) |-> bit_last)
		else $error("scan ended before the last exponent bit");
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_cnt_q <= LAST)
		else $error("step counter out of range");

endmodule
